FILE: hdl/edge_common_neighbor_count_macros.svh
// Assertion macros for the common neighbour counter checker.
// Expects clk and rst in the scope of each use.
`ifndef EDGE_COMMON_NEIGHBOR_COUNT_MACROS_SVH
`define EDGE_COMMON_NEIGHBOR_COUNT_MACROS_SVH
// Property checked only outside reset.
`define ECNC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property checked at every edge, reset included.
`define ECNC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: hdl/ecnc_pkg.sv
`timescale 1ns / 1ps
// Package for the common neighbour counter: sizes, codes and the
// controller/datapath command and status structs. No dependencies.
package ecnc_pkg;
  localparam int MAX_NODES = 4096;
  localparam int MAX_EDGES = 65536;
  localparam int NODE_AW   = $clog2(MAX_NODES);
  localparam int EDGE_AW   = $clog2(MAX_EDGES);
  localparam int NC_W      = 13;
  localparam int EC_W      = 17;
  localparam int CFG_W     = 17;
  localparam int ID_W      = 32;
  localparam int RNG_W     = 18;
  localparam int CNT_W     = 17;

  localparam logic [1:0] REQ_NODE  = 2'd0;
  localparam logic [1:0] REQ_ADJ   = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SKIP = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic CFG_NODE_COUNT = 1'b0;
  localparam logic CFG_EDGE_COUNT = 1'b1;

  typedef struct packed {
    logic signed [ID_W-1:0]  id;
    logic signed [RNG_W-1:0] rs;
    logic signed [RNG_W-1:0] re;
  } node_entry_t;

  typedef struct packed {
    logic       latch;      // capture query keys, start search on from id
    logic       next_key;   // switch search to the to id
    logic       srch_step;  // narrow lo/hi from the probed entry
    logic       take_rng;   // capture range of the found entry
    logic       merge_init;
    logic       merge_step;
    logic       res_load;
    logic [1:0] res_status;
  } ecnc_cmd_t;

  typedef struct packed {
    logic srch_more;   // lo < hi
    logic lo_in;       // lo < node count in use
    logic hit;         // probed id equals key
    logic sel_to;      // searching for the to id
    logic rng_skip;
    logic rng_err;
    logic merge_more;
  } ecnc_stat_t;
endpackage

FILE: hdl/ecnc_ctrl.sv
`timescale 1ns / 1ps
// Controller for the common neighbour counter: sequences the two searches,
// the range check and the merge walk. Depends on ecnc_pkg.
module ecnc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_accept,
  input  logic [1:0]         req_type,
  input  logic               out_stall,
  input  ecnc_pkg::ecnc_stat_t stat,
  output ecnc_pkg::ecnc_cmd_t  cmd,
  output logic               busy,
  output logic               out_valid
);
  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SCMP, S_SFIN, S_CHK, S_MRD, S_MCMP, S_RES
  } state_t;

  state_t     state, state_next;
  logic [1:0] res_st, res_st_next;

  always_comb begin
    cmd         = '0;
    cmd.res_status = res_st;
    state_next  = state;
    res_st_next = res_st;
    case (state)
      S_IDLE: begin
        if (in_accept && req_type == ecnc_pkg::REQ_QUERY) begin
          cmd.latch  = 1'b1;
          state_next = S_SRCH;
        end
      end
      S_SRCH: begin
        if (stat.srch_more) begin
          state_next = S_SCMP;
        end else if (stat.lo_in) begin
          state_next = S_SFIN;
        end else begin
          res_st_next = ecnc_pkg::ST_SKIP;
          state_next  = S_RES;
        end
      end
      S_SCMP: begin
        cmd.srch_step = 1'b1;
        state_next    = S_SRCH;
      end
      S_SFIN: begin
        if (stat.hit) begin
          cmd.take_rng = 1'b1;
          if (stat.sel_to) begin
            state_next = S_CHK;
          end else begin
            cmd.next_key = 1'b1;
            state_next   = S_SRCH;
          end
        end else begin
          res_st_next = ecnc_pkg::ST_SKIP;
          state_next  = S_RES;
        end
      end
      S_CHK: begin
        if (stat.rng_skip) begin
          res_st_next = ecnc_pkg::ST_SKIP;
          state_next  = S_RES;
        end else if (stat.rng_err) begin
          res_st_next = ecnc_pkg::ST_ERR;
          state_next  = S_RES;
        end else begin
          cmd.merge_init = 1'b1;
          state_next     = S_MRD;
        end
      end
      S_MRD: begin
        if (stat.merge_more) begin
          state_next = S_MCMP;
        end else begin
          res_st_next = ecnc_pkg::ST_OK;
          state_next  = S_RES;
        end
      end
      S_MCMP: begin
        cmd.merge_step = 1'b1;
        state_next     = S_MRD;
      end
      S_RES: begin
        if (!out_valid || !out_stall) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_st    <= ecnc_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      res_st <= res_st_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

FILE: hdl/ecnc_dp.sv
`timescale 1ns / 1ps
// Datapath for the common neighbour counter: node table and adjacency
// memories, search bounds, merge pointers and result register. Uses ecnc_pkg.
module ecnc_dp (
  input  logic                                clk,
  input  logic                                node_we,
  input  logic                                adj_we,
  input  logic [15:0]                         entry_index,
  input  logic signed [ecnc_pkg::ID_W-1:0]    node_id,
  input  logic signed [ecnc_pkg::RNG_W-1:0]   range_start,
  input  logic signed [ecnc_pkg::RNG_W-1:0]   range_end,
  input  logic signed [ecnc_pkg::ID_W-1:0]    neighbor_id,
  input  logic signed [ecnc_pkg::ID_W-1:0]    from_node,
  input  logic signed [ecnc_pkg::ID_W-1:0]    to_node,
  input  logic [ecnc_pkg::NC_W-1:0]           node_count,
  input  logic [ecnc_pkg::EC_W-1:0]           edge_count,
  input  ecnc_pkg::ecnc_cmd_t                 cmd,
  output ecnc_pkg::ecnc_stat_t                stat,
  output logic [ecnc_pkg::CNT_W-1:0]          common_count,
  output logic [1:0]                          query_status
);
  ecnc_pkg::node_entry_t node_mem [ecnc_pkg::MAX_NODES];
  logic signed [ecnc_pkg::ID_W-1:0] adj_mem [ecnc_pkg::MAX_EDGES];

  ecnc_pkg::node_entry_t            node_rd;
  logic signed [ecnc_pkg::ID_W-1:0] a_rd, b_rd;
  logic signed [ecnc_pkg::ID_W-1:0] key_from, key_to, key;
  logic [ecnc_pkg::NODE_AW:0]       lo, hi, mid, nn;
  logic [ecnc_pkg::EC_W-1:0]        ne;
  logic signed [ecnc_pkg::RNG_W-1:0] ne_s;
  logic                             sel_to;
  logic signed [ecnc_pkg::RNG_W-1:0] flb, fub, tlb, tub;
  logic [ecnc_pkg::EC_W-1:0]        i, j;
  logic [ecnc_pkg::CNT_W-1:0]       n;
  logic [ecnc_pkg::NODE_AW-1:0]     node_raddr;

  assign nn = (node_count > ecnc_pkg::NC_W'(ecnc_pkg::MAX_NODES))
            ? (ecnc_pkg::NODE_AW+1)'(ecnc_pkg::MAX_NODES)
            : (ecnc_pkg::NODE_AW+1)'(node_count);
  assign ne = (edge_count > ecnc_pkg::EC_W'(ecnc_pkg::MAX_EDGES))
            ? ecnc_pkg::EC_W'(ecnc_pkg::MAX_EDGES) : edge_count;
  assign ne_s = $signed({1'b0, ne});
  assign key  = sel_to ? key_to : key_from;
  assign mid  = lo + ((hi - lo) >> 1);
  // Probe mid while the interval is open, lo once it has closed.
  assign node_raddr = (lo < hi) ? mid[ecnc_pkg::NODE_AW-1:0]
                                : lo[ecnc_pkg::NODE_AW-1:0];

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[entry_index[ecnc_pkg::NODE_AW-1:0]] <= '{node_id, range_start, range_end};
    end
    if (adj_we) begin
      adj_mem[entry_index[ecnc_pkg::EDGE_AW-1:0]] <= neighbor_id;
    end
    node_rd <= node_mem[node_raddr];
    a_rd    <= adj_mem[i[ecnc_pkg::EDGE_AW-1:0]];
    b_rd    <= adj_mem[j[ecnc_pkg::EDGE_AW-1:0]];
  end

  always_comb begin
    stat.srch_more  = (lo < hi);
    stat.lo_in      = (lo < nn);
    stat.hit        = (node_rd.id == key);
    stat.sel_to     = sel_to;
    stat.rng_skip   = (tlb <= 0) && (tub <= 0);
    stat.rng_err    = (tub <= tlb) || (fub <= flb) || (flb < 0) || (tlb < 0) ||
                      (fub > ne_s) || (tub > ne_s) || (tlb >= ne_s);
    stat.merge_more = ($signed({1'b0, i}) < fub) && ($signed({1'b0, j}) < tub);
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      key_from <= from_node;
      key_to   <= to_node;
      sel_to   <= 1'b0;
      lo       <= '0;
      hi       <= nn;
    end
    if (cmd.next_key) begin
      sel_to <= 1'b1;
      lo     <= '0;
      hi     <= nn;
    end
    if (cmd.srch_step) begin
      if (node_rd.id < key) begin
        lo <= mid + 1'b1;
      end else begin
        hi <= mid;
      end
    end
    if (cmd.take_rng) begin
      if (sel_to) begin
        tlb <= node_rd.rs;
        tub <= node_rd.re;
      end else begin
        flb <= node_rd.rs;
        fub <= node_rd.re;
      end
    end
    if (cmd.merge_init) begin
      i <= flb[ecnc_pkg::EC_W-1:0];
      j <= tlb[ecnc_pkg::EC_W-1:0];
      n <= '0;
    end
    if (cmd.merge_step) begin
      if (a_rd == b_rd) begin
        n <= n + 1'b1;
        i <= i + 1'b1;
        j <= j + 1'b1;
      end else if (a_rd < b_rd) begin
        i <= i + 1'b1;
      end else begin
        j <= j + 1'b1;
      end
    end
    if (cmd.res_load) begin
      query_status <= cmd.res_status;
      common_count <= (cmd.res_status == ecnc_pkg::ST_OK) ? n : '0;
    end
  end
endmodule

FILE: hdl/edge_common_neighbor_count.sv
`timescale 1ns / 1ps
// Common neighbour counter, top level. Loads give no result beat.
// A query runs a binary search of the node table for each of its two ids,
// a range check, then a merge walk over both neighbour lists in the
// adjacency memory.
// Synchronous active-high reset clears the count registers and control; the
// datapath registers are not reset and memories are undefined until loaded.
module edge_common_neighbor_count (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [ecnc_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        req_type,
  input  logic [15:0]                       entry_index,
  input  logic signed [ecnc_pkg::ID_W-1:0]  node_id,
  input  logic signed [ecnc_pkg::RNG_W-1:0] range_start,
  input  logic signed [ecnc_pkg::RNG_W-1:0] range_end,
  input  logic signed [ecnc_pkg::ID_W-1:0]  neighbor_id,
  input  logic signed [ecnc_pkg::ID_W-1:0]  from_node,
  input  logic signed [ecnc_pkg::ID_W-1:0]  to_node,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ecnc_pkg::CNT_W-1:0]        common_count,
  output logic [1:0]                        query_status
);
  logic [ecnc_pkg::NC_W-1:0] node_count;
  logic [ecnc_pkg::EC_W-1:0] edge_count;
  logic                      in_accept;
  logic                      busy;
  ecnc_pkg::ecnc_cmd_t       cmd;
  ecnc_pkg::ecnc_stat_t      stat;
  logic                      node_we, adj_we;

  // Configuration registers: write straight through, no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
      edge_count <= '0;
    end else if (cfg_we) begin
      if (cfg_index == ecnc_pkg::CFG_NODE_COUNT) begin
        node_count <= cfg_data[ecnc_pkg::NC_W-1:0];
      end else begin
        edge_count <= cfg_data[ecnc_pkg::EC_W-1:0];
      end
    end
  end

  // Hold new beats while a query is in flight; a finished result may still
  // wait in the output register while the next beat is taken.
  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;
  // Drop loads whose index lies beyond the store.
  assign node_we = in_accept && (req_type == ecnc_pkg::REQ_NODE) &&
                   ({1'b0, entry_index} < 17'(ecnc_pkg::MAX_NODES));
  assign adj_we  = in_accept && (req_type == ecnc_pkg::REQ_ADJ) &&
                   ({1'b0, entry_index} < 17'(ecnc_pkg::MAX_EDGES));

  ecnc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .req_type  (req_type),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ecnc_dp u_dp (
    .clk          (clk),
    .node_we      (node_we),
    .adj_we       (adj_we),
    .entry_index  (entry_index),
    .node_id      (node_id),
    .range_start  (range_start),
    .range_end    (range_end),
    .neighbor_id  (neighbor_id),
    .from_node    (from_node),
    .to_node      (to_node),
    .node_count   (node_count),
    .edge_count   (edge_count),
    .cmd          (cmd),
    .stat         (stat),
    .common_count (common_count),
    .query_status (query_status)
  );
endmodule

FILE: hdl/ecnc_checker.sv
`timescale 1ns / 1ps
// Port checker for the common neighbour counter, bound to the top level.
// Depends on ecnc_pkg and edge_common_neighbor_count_macros.svh.
`include "edge_common_neighbor_count_macros.svh"
module ecnc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [ecnc_pkg::CNT_W-1:0] common_count,
  input logic [1:0]                 query_status
);
  `ECNC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result beat dropped")
  `ECNC_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(common_count) && $stable(query_status), "stalled result changed")
  `ECNC_ASSERT(a_zero_on_fail, out_valid && query_status != ecnc_pkg::ST_OK |-> common_count == '0, "nonzero count on skip or error")
  `ECNC_ASSERT_ALWAYS(a_rst_clear, rst |=> !out_valid, "result beat after reset")
endmodule

bind edge_common_neighbor_count ecnc_checker u_ecnc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .common_count (common_count),
  .query_status (query_status)
);

FILE: sim/tb_edge_common_neighbor_count.sv
`timescale 1ns / 1ps
// Self-checking testbench for edge_common_neighbor_count: a directed table, a large
// node table, then phases of node/adjacency loads mixed with random queries, each
// checked against a local predictor or a typed-in result. Depends on ecnc_pkg.
module tb_edge_common_neighbor_count;
  localparam int MAX_NODES = ecnc_pkg::MAX_NODES;
  localparam int MAX_EDGES = ecnc_pkg::MAX_EDGES;
  localparam int CFG_W     = ecnc_pkg::CFG_W;
  localparam int ID_W      = ecnc_pkg::ID_W;
  localparam int RNG_W     = ecnc_pkg::RNG_W;
  localparam int CNT_W     = ecnc_pkg::CNT_W;
  localparam int NC_W      = ecnc_pkg::NC_W;
  localparam int EC_W      = ecnc_pkg::EC_W;
  localparam logic [1:0] REQ_NODE  = ecnc_pkg::REQ_NODE;
  localparam logic [1:0] REQ_ADJ   = ecnc_pkg::REQ_ADJ;
  localparam logic [1:0] REQ_QUERY = ecnc_pkg::REQ_QUERY;
  localparam logic [1:0] ST_OK     = ecnc_pkg::ST_OK;
  localparam logic [1:0] ST_SKIP   = ecnc_pkg::ST_SKIP;
  localparam logic [1:0] ST_ERR    = ecnc_pkg::ST_ERR;
  localparam logic CFG_NODE_COUNT  = ecnc_pkg::CFG_NODE_COUNT;
  localparam logic CFG_EDGE_COUNT  = ecnc_pkg::CFG_EDGE_COUNT;

  localparam int IDLE_LIMIT  = 50000;  // cycles with no beat before giving up
  localparam int SETTLE_CYC  = 16;     // let a trailing load retire
  localparam int ITEMS_TOTAL = 1450;   // input beats over the whole run
  localparam int QUIET_AFTER = 1250;   // no idling past this many beats
  localparam int NODE_FILL   = 256;    // entries in the large node table
  localparam int ADJ_FILL    = 40;     // adjacency entries behind it
  localparam logic [1:0] REQ_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = REQ_NONE;
  logic [15:0] entry_index = '0;
  logic signed [ID_W-1:0] node_id = '0;
  logic signed [RNG_W-1:0] range_start = '0;
  logic signed [RNG_W-1:0] range_end = '0;
  logic signed [ID_W-1:0] neighbor_id = '0;
  logic signed [ID_W-1:0] from_node = '0;
  logic signed [ID_W-1:0] to_node = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CNT_W-1:0] common_count;
  logic [1:0] query_status;

  edge_common_neighbor_count dut (.*);

  always #6 clk = ~clk;

  typedef struct {
    bit               is_cfg;
    logic             cfg_i;
    logic [CFG_W-1:0] cfg_v;
    logic [1:0]       rt;
    logic [15:0]      idx;
    int               nid;
    int               rs;
    int               re;
    int               nb;
    int               src;
    int               dst;
    bit               fixed;   // expected result typed into the row
    logic [CNT_W-1:0] ecnt;
    logic [1:0]       est;
  } beat_t;

  typedef struct {
    logic [CNT_W-1:0] cnt;
    logic [1:0]       st;
  } tally_t;

  // Local copy of the block's state
  int node_tab[MAX_NODES];
  int start_tab[MAX_NODES];
  int end_tab[MAX_NODES];
  int adj_tab[MAX_EDGES];
  int nodes_used = 0;
  int edges_used = 0;

  tally_t pending_tallies[$];
  int fails = 0;
  int queries_sent = 0, loads_sent = 0, items_sent = 0;
  bit quiet = 1'b0;
  bit in_beat, out_beat;

  // Lower-bound search over the node table; -1 when the id is absent
  function automatic int find_node(int key);
    int lo, hi, mid, n;
    n = nodes_used > MAX_NODES ? MAX_NODES : nodes_used;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (node_tab[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    if (lo < n && node_tab[lo] == key) return lo;
    return -1;
  endfunction

  function automatic tally_t count_common(int src, int dst);
    tally_t t;
    int fp, tp, flb, fub, tlb, tub, i, j, ne, n;
    t.cnt = '0;
    t.st = ST_SKIP;
    ne = edges_used > MAX_EDGES ? MAX_EDGES : edges_used;
    fp = find_node(src);
    if (fp < 0) return t;
    tp = find_node(dst);
    if (tp < 0) return t;
    flb = start_tab[fp];
    fub = end_tab[fp];
    tlb = start_tab[tp];
    tub = end_tab[tp];
    if (tlb <= 0 && tub <= 0) return t;
    if (tub <= tlb || fub <= flb || flb < 0 || tlb < 0 ||
        fub > ne || tub > ne || tlb >= ne) begin
      t.st = ST_ERR;
      return t;
    end
    i = flb;
    j = tlb;
    n = 0;
    while (i < fub && j < tub) begin
      if (adj_tab[i] == adj_tab[j]) begin
        n++;
        i++;
        j++;
      end else if (adj_tab[i] < adj_tab[j]) i++;
      else j++;
    end
    t.cnt = n[CNT_W-1:0];
    t.st = ST_OK;
    return t;
  endfunction

  // Update local state for an accepted beat and queue its tally
  task automatic absorb(beat_t b);
    tally_t t;
    case (b.rt)
      REQ_NODE: begin
        loads_sent++;
        if (b.idx < MAX_NODES) begin
          node_tab[b.idx] = b.nid;
          start_tab[b.idx] = b.rs;
          end_tab[b.idx] = b.re;
        end
      end
      REQ_ADJ: begin
        loads_sent++;
        adj_tab[b.idx] = b.nb;
      end
      REQ_QUERY: begin
        queries_sent++;
        if (b.fixed) begin
          t.cnt = b.ecnt;
          t.st = b.est;
        end else begin
          t = count_common(b.src, b.dst);
        end
        pending_tallies.push_back(t);
      end
      default: ;
    endcase
  endtask

  // Present one beat, with an optional gap first, and hold until accepted
  task automatic send(beat_t b);
    logic signed [RNG_W-1:0] rs18, re18;
    rs18 = RNG_W'(b.rs);
    re18 = RNG_W'(b.re);
    b.rs = rs18;
    b.re = re18;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_type <= b.rt;
    entry_index <= b.idx;
    node_id <= b.nid;
    range_start <= rs18;
    range_end <= re18;
    neighbor_id <= b.nb;
    from_node <= b.src;
    to_node <= b.dst;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    absorb(b);
    items_sent++;
    if (items_sent >= QUIET_AFTER) quiet = 1'b1;
  endtask

  // Drop valid and wait until every tally is back and the block is idle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_NODE_COUNT) nodes_used = val[NC_W-1:0];
    else edges_used = val[EC_W-1:0];
  endtask

  function automatic beat_t blank();
    beat_t b;
    b = '{default: 0};
    b.rt = REQ_NONE;
    return b;
  endfunction

  function automatic beat_t mk_node(int idx, int nid, int rs, int re);
    beat_t b;
    b = blank();
    b.rt = REQ_NODE;
    b.idx = 16'(idx);
    b.nid = nid;
    b.rs = rs;
    b.re = re;
    return b;
  endfunction

  function automatic beat_t mk_adj(int idx, int nb);
    beat_t b;
    b = blank();
    b.rt = REQ_ADJ;
    b.idx = 16'(idx);
    b.nb = nb;
    return b;
  endfunction

  function automatic beat_t mk_query(int src, int dst, bit fixed = 0,
                                     int ecnt = 0, logic [1:0] est = ST_OK);
    beat_t b;
    b = blank();
    b.rt = REQ_QUERY;
    b.src = src;
    b.dst = dst;
    b.fixed = fixed;
    b.ecnt = CNT_W'(ecnt);
    b.est = est;
    return b;
  endfunction

  function automatic beat_t mk_cfg(logic idx, int val);
    beat_t b;
    b = blank();
    b.is_cfg = 1'b1;
    b.cfg_i = idx;
    b.cfg_v = CFG_W'(val);
    return b;
  endfunction

  // Adjacency range: mostly inside the written prefix, sometimes broken.
  // Ranges that pass the block's checks never reach past the written prefix.
  task automatic pick_range(int w, output int s, output int e);
    int ne;
    ne = edges_used > MAX_EDGES ? MAX_EDGES : edges_used;
    case ($urandom_range(0, 19))
      0: begin s = -1; e = -1; end
      1: begin s = 0; e = 0; end
      2: begin s = -1; e = $urandom_range(0, w); end
      3: begin s = $urandom_range(1, w + 1); e = s - 1; end
      4: begin
        s = $urandom_range(0, w);
        e = (ne < MAX_EDGES) ? ne + $urandom_range(1, 5) : s;
      end
      default: begin
        s = $urandom_range(0, w);
        e = $urandom_range(s, w);
      end
    endcase
  endtask

  // Non-decreasing ids in small or, when wide, large steps, so that queries find shared neighbours
  task automatic next_id(inout longint acc, input bit wide);
    acc += wide ? longint'($urandom_range(0, 32'h0100_0000)) : $urandom_range(0, 3);
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
  endtask

  // One phase: fill both stores, set the counts, then mixed loads and queries
  task automatic run_phase(int n, int w, int ec_val, int items);
    longint acc;
    int s, e, k, pick;
    bit wide, messy;
    beat_t b;
    drain();
    write_reg(CFG_NODE_COUNT, '0);
    write_reg(CFG_EDGE_COUNT, CFG_W'(ec_val));
    wide = ($urandom_range(0, 4) == 0);
    messy = ($urandom_range(0, 9) == 0);
    acc = longint'($signed($urandom())) - (wide ? 64'sd0 : 64'sd0);
    if (wide) acc = -64'sd2147483648 + $urandom_range(0, 1000);
    for (k = 0; k < w; k++) begin
      next_id(acc, 1'b0);
      send(mk_adj(k, messy ? int'($urandom()) : int'(acc)));
    end
    acc = longint'($signed($urandom_range(0, 200))) - 100;
    if (wide) acc = -64'sd2147483648;
    for (k = 0; k < n; k++) begin
      next_id(acc, wide);
      pick_range(w, s, e);
      send(mk_node(k, int'(acc), s, e));
    end
    drain();
    write_reg(CFG_NODE_COUNT, CFG_W'(n));
    for (k = 0; k < items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        b = mk_query(node_tab[$urandom_range(0, n - 1)], node_tab[$urandom_range(0, n - 1)]);
        if ($urandom_range(0, 7) == 0) b.src = $urandom();
        else if ($urandom_range(0, 7) == 0) b.dst = b.dst + 1;
      end else if (pick < 75) begin
        pick_range(w, s, e);
        b = mk_node($urandom_range(0, n - 1), node_tab[$urandom_range(0, n - 1)], s, e);
      end else if (pick < 83) begin
        b = mk_adj($urandom_range(0, w - 1), $urandom());
      end else if (pick < 90) begin
        // ignored: node load beyond the table, full-width garbage
        b = mk_node($urandom_range(MAX_NODES, 65535), $urandom(),
                    $urandom_range(0, 32'h3FFFF), $urandom_range(0, 32'h3FFFF));
        if ($urandom_range(0, 1)) begin
          b.rs = $signed(18'sh20000 | 18'($urandom()));
          b.re = 65536;
        end
      end else if (pick < 95) begin
        // real write, but outside any range in use
        b = mk_adj($urandom_range(w, 65535), $urandom());
      end else begin
        b = blank();
        b.idx = 16'($urandom());
        b.src = $urandom();
        b.dst = $urandom();
      end
      send(b);
    end
  endtask

  // Result checking: each result beat against the oldest tally waiting
  always @(posedge clk) begin
    tally_t t;
    if (!rst && out_valid && !out_stall) begin
      if (pending_tallies.size() == 0) begin
        $error("unexpected result beat: common_count=%0d query_status=%0d",
               common_count, query_status);
        fails++;
      end else begin
        t = pending_tallies.pop_front();
        if (common_count !== t.cnt) begin
          $error("common_count: expected %0d, got %0d", t.cnt, common_count);
          fails++;
        end
        if (query_status !== t.st) begin
          $error("query_status: expected %0d, got %0d", t.st, query_status);
          fails++;
        end
      end
    end
  end

  // Receiver stall: random bursts, calm stretches, none in the last part
  int stall_left = 0;
  bit calm = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) calm <= ~calm;
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 5);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: count cycles in which no beat moves on either side
  int idle_cycles = 0;
  always @(posedge clk) begin
    in_beat = in_valid && !in_stall;
    out_beat = out_valid && !out_stall;
    if (rst || in_beat || out_beat || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  beat_t table_rows[$];

  initial begin
    int k, s, e;
    longint acc;
    beat_t b;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty table, ignored requests, then a tiny graph
    table_rows.push_back(mk_query(32'sh8000_0000, 32'sh7FFF_FFFF, 1, 0, ST_SKIP));
    b = blank();
    b.idx = 16'hFFFF;
    b.src = -1;
    b.dst = -1;
    table_rows.push_back(b);
    table_rows.push_back(mk_node(16'hFFFF, 32'sh7FFF_FFFF, 65536, -1));
    table_rows.push_back(mk_node(MAX_NODES, 32'sh8000_0000, -1, 65536));
    table_rows.push_back(mk_adj(16'hFFFF, 32'sh8000_0000));
    table_rows.push_back(mk_adj(0, 1));
    table_rows.push_back(mk_adj(1, 2));
    table_rows.push_back(mk_adj(2, 3));
    table_rows.push_back(mk_adj(3, 9));
    table_rows.push_back(mk_node(0, -5, 0, 2));
    table_rows.push_back(mk_node(1, 7, 1, 4));
    table_rows.push_back(mk_cfg(CFG_NODE_COUNT, 2));
    table_rows.push_back(mk_cfg(CFG_EDGE_COUNT, 4));
    table_rows.push_back(mk_query(-5, 7));
    table_rows.push_back(mk_query(-5, -5));
    table_rows.push_back(mk_query(8, 7, 1, 0, ST_SKIP));
    table_rows.push_back(mk_node(1, 7, 0, 0));
    table_rows.push_back(mk_query(-5, 7, 1, 0, ST_SKIP));
    table_rows.push_back(mk_node(1, 7, -1, -1));
    table_rows.push_back(mk_query(-5, 7, 1, 0, ST_SKIP));
    table_rows.push_back(mk_node(1, 7, 3, 2));
    table_rows.push_back(mk_query(-5, 7, 1, 0, ST_ERR));
    table_rows.push_back(mk_node(1, 7, 1, 5));
    table_rows.push_back(mk_query(-5, 7, 1, 0, ST_ERR));
    table_rows.push_back(mk_node(1, 7, 0, 4));
    table_rows.push_back(mk_node(0, 7, -1, 2));
    table_rows.push_back(mk_query(7, 7, 1, 0, ST_ERR));
    table_rows.push_back(mk_query(7, 7));
    foreach (table_rows[i]) begin
      if (table_rows[i].is_cfg) begin
        drain();
        write_reg(table_rows[i].cfg_i, table_rows[i].cfg_v);
      end else begin
        send(table_rows[i]);
      end
    end

    // Larger node table with extreme ids; edge count past the maximum.
    // Write a few adjacency entries past the edge count so that ranges
    // cut off now stay on written entries once the count is raised.
    drain();
    write_reg(CFG_NODE_COUNT, '0);
    write_reg(CFG_EDGE_COUNT, CFG_W'(32));
    for (k = 0; k < ADJ_FILL; k++) send(mk_adj(k, k / 2));
    acc = -64'sd2147483648;
    for (k = 0; k < NODE_FILL; k++) begin
      if (k == NODE_FILL - 1) acc = 64'sd2147483647;
      pick_range(32, s, e);
      send(mk_node(k, int'(acc), s, e));
      acc += 3;
    end
    drain();
    write_reg(CFG_NODE_COUNT, CFG_W'(NODE_FILL));
    write_reg(CFG_EDGE_COUNT, 17'h1FFFF);
    for (k = 0; k < 30; k++)
      send(mk_query(node_tab[$urandom_range(0, NODE_FILL - 1)],
                    node_tab[$urandom_range(0, NODE_FILL - 1)]));
    send(mk_query(32'sh7FFF_FFFF, 32'sh8000_0000));
    drain();
    write_reg(CFG_EDGE_COUNT, CFG_W'(MAX_EDGES));
    for (k = 0; k < 20; k++)
      send(mk_query(node_tab[$urandom_range(0, NODE_FILL - 1)],
                    node_tab[$urandom_range(0, NODE_FILL - 1)] + $urandom_range(0, 1)));

    // Random phases; edge count swings between tight, loose and extreme
    while (items_sent < ITEMS_TOTAL) begin
      k = $urandom_range(1, 48);
      case ($urandom_range(0, 5))
        0: s = 0;
        1: s = $urandom_range(0, k);
        2: s = MAX_EDGES;
        3: s = 17'h1FFFF;
        default: s = k + $urandom_range(0, 8);
      endcase
      run_phase($urandom_range(1, 16), k, s, $urandom_range(30, 70));
    end

    drain();
    in_valid <= 1'b0;
    $display("Covered %0d queries and %0d loads; directed edge cases, a 256-entry node table",
             queries_sent, loads_sent);
    $display("and random phases with sorted, unsorted and broken ranges under stalls.");
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+hdl
hdl/ecnc_pkg.sv
hdl/ecnc_ctrl.sv
hdl/ecnc_dp.sv
hdl/edge_common_neighbor_count.sv
hdl/ecnc_checker.sv
sim/tb_edge_common_neighbor_count.sv
